### hdl/pdb_pkg.sv
// Package for the parking distance beeper: request codes, register indexes,
// reset values and the echo-to-centimetre reciprocal constants.
// No dependencies.
`default_nettype none

package pdb_pkg;

    // Request kinds on the input channel
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_ECHO = 1'b1;

    // Register index map of the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_PERIOD = 3'd0,
        CFG_ZONE_STEP      = 3'd1,
        CFG_BEEP_NEAR      = 3'd2,
        CFG_BEEP_MID       = 3'd3,
        CFG_BEEP_FAR       = 3'd4,
        CFG_BEEP_EDGE      = 3'd5
    } cfg_idx_t;

    localparam int unsigned MS_W   = 10;
    localparam int unsigned STEP_W = 7;
    localparam int unsigned ECHO_W = 15;
    localparam int unsigned CM_W   = 10;
    localparam int unsigned ZONE_W = 3;
    localparam int unsigned DATA_W = 10;

    typedef logic [MS_W-1:0]   ms_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [CM_W-1:0]   cm_t;
    typedef logic [ZONE_W-1:0] zone_t;

    localparam ms_t   MS_MAX              = '1;
    localparam ms_t   RST_TRIGGER_PERIOD  = 10'd100;
    localparam step_t RST_ZONE_STEP       = 7'd10;
    localparam ms_t   RST_BEEP_NEAR       = 10'd50;
    localparam ms_t   RST_BEEP_MID        = 10'd150;
    localparam ms_t   RST_BEEP_FAR        = 10'd300;
    localparam ms_t   RST_BEEP_EDGE       = 10'd600;

    // cm = floor(us * 343 / 20000) = (us * ceil(343 * 2^30 / 20000)) >> 30,
    // exact for every 15-bit echo value.
    localparam int unsigned ECHO_RECIP_W = 25;
    localparam int unsigned ECHO_SHIFT   = 30;
    localparam int unsigned ECHO_PROD_W  = ECHO_W + ECHO_RECIP_W;
    localparam logic [ECHO_RECIP_W-1:0] ECHO_RECIP = 25'd18414673;

    localparam zone_t ZONES_ALL  = 3'd4;
    localparam zone_t ZONES_NONE = 3'd0;

    // Result item as held in the output register
    typedef struct packed {
        logic  trigger_start;
        logic  buzzer_on;
        zone_t filled_zones;
        cm_t   range_cm;
    } result_t;

endpackage

`default_nettype wire

### hdl/parking_distance_beeper.sv
// Parking distance beeper: tick/echo request processing, trigger timing,
// distance banding and buzzer toggling in one registered pass.
// Depends on pdb_pkg.
//
// Usage
//   Input channel (s_valid/s_ready): one request per handshake. s_req_type
//   REQ_TICK is a one-millisecond tick, REQ_ECHO carries the echo high time
//   in s_echo_us (zero = timeout, silences the buzzer).
//   Result channel (m_valid/m_ready): exactly one result per request, in
//   order: trigger request, buzzer level, lit zones and last distance.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index in the
//   same edge; write only while no request is in flight.
// Timing
//   An accepted request sits in the input register, is processed there by
//   one multiply (echo to cm) plus compares, and its result is then loaded
//   into the output register once that register is free or the sink takes
//   its item. Throughput is one request per cycle while m_ready stays high;
//   the echo multiply and band compares set the critical path.
// Reset and stall
//   aresetn low clears both pipeline valids, all counters, the distance,
//   the beep interval and the buzzer, and reloads the register defaults.
//   When m_ready is low the output register holds; one more request can be
//   taken into the input register, then s_ready drops until the sink moves.
`default_nettype none

module parking_distance_beeper (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [pdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pdb_pkg::DATA_W-1:0]    cfg_wdata,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [pdb_pkg::ECHO_W-1:0]    s_echo_us,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_trigger_start,
    output logic                               m_buzzer_on,
    output logic [pdb_pkg::ZONE_W-1:0]         m_filled_zones,
    output logic [pdb_pkg::CM_W-1:0]           m_range_cm
);
    import pdb_pkg::*;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    ms_t   trigger_period_reg;
    step_t zone_step_reg;
    ms_t   beep_near_reg;
    ms_t   beep_mid_reg;
    ms_t   beep_far_reg;
    ms_t   beep_edge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_period_reg <= RST_TRIGGER_PERIOD;
            zone_step_reg      <= RST_ZONE_STEP;
            beep_near_reg      <= RST_BEEP_NEAR;
            beep_mid_reg       <= RST_BEEP_MID;
            beep_far_reg       <= RST_BEEP_FAR;
            beep_edge_reg      <= RST_BEEP_EDGE;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TRIGGER_PERIOD: trigger_period_reg <= cfg_wdata[MS_W-1:0];
                CFG_ZONE_STEP:      zone_step_reg      <= cfg_wdata[STEP_W-1:0];
                CFG_BEEP_NEAR:      beep_near_reg      <= cfg_wdata[MS_W-1:0];
                CFG_BEEP_MID:       beep_mid_reg       <= cfg_wdata[MS_W-1:0];
                CFG_BEEP_FAR:       beep_far_reg       <= cfg_wdata[MS_W-1:0];
                CFG_BEEP_EDGE:      beep_edge_reg      <= cfg_wdata[MS_W-1:0];
                default: ;  // unmapped index: write is dropped
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline handshake: input register -> processing -> output register
    // ---------------------------------------------------------------------
    logic                in_valid_reg;
    logic                in_type_reg;
    logic [ECHO_W-1:0]   in_echo_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg <= s_req_type;
            in_echo_reg <= s_echo_us;
        end
    end

    // ---------------------------------------------------------------------
    // Block state
    // ---------------------------------------------------------------------
    ms_t  since_trigger_reg, since_trigger_next;
    ms_t  since_toggle_reg,  since_toggle_next;
    cm_t  measured_cm_reg,   measured_cm_next;
    ms_t  beep_interval_reg, beep_interval_next;
    logic buzzer_reg,        buzzer_next;
    logic trig_next;

    // Echo to centimetres: single constant multiply, top bits kept
    logic [ECHO_PROD_W-1:0] echo_prod;
    cm_t                    echo_cm;

    assign echo_prod = ECHO_PROD_W'(in_echo_reg) * ECHO_PROD_W'(ECHO_RECIP);
    assign echo_cm   = echo_prod[ECHO_SHIFT +: CM_W];

    // Zone boundaries; 4 * 127 still fits in 10 bits
    cm_t step_x1, step_x2, step_x3, step_x4;

    assign step_x1 = CM_W'(zone_step_reg);
    assign step_x2 = CM_W'({zone_step_reg, 1'b0});
    assign step_x4 = CM_W'({zone_step_reg, 2'b00});
    assign step_x3 = step_x1 + step_x2;

    // Band compares run on the distance after this request
    logic in_x1, in_x2, in_x3, in_x4;
    ms_t  band_ms;

    assign in_x1 = (measured_cm_next <= step_x1);
    assign in_x2 = (measured_cm_next <= step_x2);
    assign in_x3 = (measured_cm_next <= step_x3);
    assign in_x4 = (measured_cm_next <= step_x4);

    always_comb begin
        if (in_x1) begin
            band_ms = beep_near_reg;
        end else if (in_x2) begin
            band_ms = beep_mid_reg;
        end else if (in_x3) begin
            band_ms = beep_far_reg;
        end else if (in_x4) begin
            band_ms = beep_edge_reg;
        end else begin
            band_ms = '0;
        end
    end

    ms_t  tick_trigger;
    ms_t  tick_toggle;
    ms_t  toggle_count;
    logic buzzer_mid;

    assign tick_trigger = (since_trigger_reg == MS_MAX) ? MS_MAX : since_trigger_reg + 1'b1;
    assign tick_toggle  = (since_toggle_reg  == MS_MAX) ? MS_MAX : since_toggle_reg  + 1'b1;

    always_comb begin
        trig_next          = 1'b0;
        since_trigger_next = since_trigger_reg;
        toggle_count       = since_toggle_reg;
        measured_cm_next   = measured_cm_reg;
        beep_interval_next = beep_interval_reg;
        buzzer_mid         = buzzer_reg;
        since_toggle_next  = since_toggle_reg;
        buzzer_next        = buzzer_reg;

        // request-specific update
        if (in_type_reg == REQ_TICK) begin
            toggle_count = tick_toggle;
            if (tick_trigger >= trigger_period_reg) begin
                trig_next          = 1'b1;
                since_trigger_next = '0;
            end else begin
                since_trigger_next = tick_trigger;
            end
        end else if (in_echo_reg != '0) begin
            measured_cm_next   = echo_cm;
            beep_interval_next = band_ms;
            if (band_ms == '0) begin
                buzzer_mid = 1'b0;
            end
        end else begin
            // timeout: silence, keep last distance
            beep_interval_next = '0;
            buzzer_mid         = 1'b0;
        end

        // common buzzer step after every request
        since_toggle_next = toggle_count;
        buzzer_next       = buzzer_mid;
        if ((beep_interval_next != '0) && in_x4) begin
            if (toggle_count >= beep_interval_next) begin
                since_toggle_next = '0;
                buzzer_next       = !buzzer_mid;
            end
        end else begin
            buzzer_next = 1'b0;
        end
    end

    // Lit zones: 4 - d/step by compares, d known to be at most 4 steps
    zone_t zones_next;

    always_comb begin
        if (!in_x4) begin
            zones_next = ZONES_NONE;
        end else if (zone_step_reg == '0) begin
            zones_next = ZONES_ALL;
        end else if (measured_cm_next < step_x1) begin
            zones_next = 3'd4;
        end else if (measured_cm_next < step_x2) begin
            zones_next = 3'd3;
        end else if (measured_cm_next < step_x3) begin
            zones_next = 3'd2;
        end else if (measured_cm_next < step_x4) begin
            zones_next = 3'd1;
        end else begin
            zones_next = ZONES_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_trigger_reg <= '0;
            since_toggle_reg  <= '0;
            measured_cm_reg   <= '0;
            beep_interval_reg <= '0;
            buzzer_reg        <= 1'b0;
        end else if (advance) begin
            since_trigger_reg <= since_trigger_next;
            since_toggle_reg  <= since_toggle_next;
            measured_cm_reg   <= measured_cm_next;
            beep_interval_reg <= beep_interval_next;
            buzzer_reg        <= buzzer_next;
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg.trigger_start <= trig_next;
            out_reg.buzzer_on     <= buzzer_next;
            out_reg.filled_zones  <= zones_next;
            out_reg.range_cm      <= measured_cm_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_trigger_start = out_reg.trigger_start;
    assign m_buzzer_on     = out_reg.buzzer_on;
    assign m_filled_zones  = out_reg.filled_zones;
    assign m_range_cm      = out_reg.range_cm;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // echo requests never raise a trigger
    a_echo_no_trigger: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_type_reg == REQ_ECHO) |=> !m_trigger_start)
        else $error("trigger raised by echo request");

    // buzzer only sounds with a nonzero interval
    a_buzzer_needs_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        buzzer_reg |-> (beep_interval_reg != '0))
        else $error("buzzer on while silent");

    // the trigger counter is cleared before it can saturate
    a_trigger_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        since_trigger_reg != MS_MAX)
        else $error("trigger counter saturated");

    // full pipeline with a stalled sink takes nothing in
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken into a full pipeline");

    // lit zones stay within four
    a_zones_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_filled_zones <= ZONES_ALL))
        else $error("zone count out of range");

endmodule

`default_nettype wire
